[src/cln_pkg.sv]
// ----------------------------------------------------------------------------
// cln_pkg: shared types and constants of the lcd number formatter
// request codes, lcd bus constants, job header and sequencer state types
// ----------------------------------------------------------------------------
`default_nettype none

package cln_pkg;

  // default and upper bound of the digit store
  localparam int unsigned DefaultMaxDigits = 16;
  localparam int unsigned SrcDigits        = 16;
  localparam int unsigned BcdDigits        = 5;

  // request codes
  localparam logic [2:0] ActUnsigned = 3'd0;
  localparam logic [2:0] ActSigned   = 3'd1;
  localparam logic [2:0] ActHex      = 3'd2;
  localparam logic [2:0] ActBinary   = 3'd3;
  localparam logic [2:0] ActChar     = 3'd4;

  localparam logic [1:0] FirstLine   = 2'd1;

  // lcd bus constants
  localparam logic [7:0] CmdSetAddr  = 8'h80;
  localparam logic [7:0] Line2Offset = 8'h40;
  localparam logic [7:0] AsciiZero   = 8'h30;
  localparam logic [7:0] AsciiUpperA = 8'h41;
  localparam logic [7:0] AsciiPlus   = 8'h2B;
  localparam logic [7:0] AsciiMinus  = 8'h2D;

  typedef struct packed {
    logic [7:0] addr_cmd;
    logic       has_prefix;
    logic [7:0] prefix_byte;
  } job_hdr_t;

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_CONV,
    FR_PUSH
  } fr_state_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_PREFIX,
    BK_DIGITS
  } bk_state_e;

  // one digit value to its ascii character
  function automatic logic [7:0] digit_to_ascii(input logic [3:0] d);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = AsciiZero + {4'b0, d};
    end else begin
      c = AsciiUpperA + {4'b0, d} - 8'd10;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[src/cln_front.sv]
// ----------------------------------------------------------------------------
// cln_front: request intake and digit preparation
// decodes a request, builds the address command and prefix, converts decimal
// values to bcd one bit per cycle and hands a finished job to the queue
// ----------------------------------------------------------------------------
`default_nettype none

module cln_front #(
  parameter int unsigned MAX_DIGITS = cln_pkg::DefaultMaxDigits,
  localparam int unsigned CntW = $clog2(MAX_DIGITS + 1)
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_ready_o,
  input  wire logic [2:0]              action_i,
  input  wire logic [1:0]              line_i,
  input  wire logic [5:0]              column_i,
  input  wire logic [15:0]             number_i,
  input  wire logic [4:0]              digit_count_i,
  input  wire logic [7:0]              char_code_i,
  output logic                         job_valid_o,
  input  wire logic                    job_ready_i,
  output cln_pkg::job_hdr_t            job_hdr_o,
  output logic [CntW-1:0]              job_cnt_o,
  output logic [4*MAX_DIGITS-1:0]      job_digits_o
);

  localparam int unsigned SrcW = 4 * cln_pkg::SrcDigits;
  localparam int unsigned BcdW = 4 * cln_pkg::BcdDigits;

  cln_pkg::fr_state_e state_q, state_d;
  cln_pkg::job_hdr_t  hdr_q, hdr_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic [15:0]        mag_q, mag_d;
  logic [BcdW-1:0]    bcd_q, bcd_d;
  logic [3:0]         bit_q, bit_d;
  logic               is_dec_q, is_dec_d;
  logic               is_bin_q, is_bin_d;

  logic               accept;
  logic [7:0]         addr_base;
  logic [7:0]         addr_sel;
  logic [BcdW-1:0]    bcd_adj;
  logic [SrcW-1:0]    src_digits;

  assign in_ready_o = (state_q == cln_pkg::FR_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  // add-three correction before each shift
  always_comb begin
    for (int k = 0; k < int'(cln_pkg::BcdDigits); k++) begin
      if (bcd_q[4*k +: 4] >= 4'd5) begin
        bcd_adj[4*k +: 4] = bcd_q[4*k +: 4] + 4'd3;
      end else begin
        bcd_adj[4*k +: 4] = bcd_q[4*k +: 4];
      end
    end
  end

  always_comb begin
    addr_base = {2'b00, column_i} + 8'hFF;
    if (line_i == cln_pkg::FirstLine) begin
      addr_sel = addr_base;
    end else begin
      addr_sel = addr_base + cln_pkg::Line2Offset;
    end
  end

  always_comb begin
    state_d     = state_q;
    hdr_d       = hdr_q;
    cnt_d       = cnt_q;
    mag_d       = mag_q;
    bcd_d       = bcd_q;
    bit_d       = bit_q;
    is_dec_d    = is_dec_q;
    is_bin_d    = is_bin_q;
    job_valid_o = 1'b0;
    case (state_q)
      cln_pkg::FR_IDLE: begin
        if (accept) begin
          hdr_d.addr_cmd    = cln_pkg::CmdSetAddr | addr_sel;
          hdr_d.has_prefix  = (action_i == cln_pkg::ActSigned) ||
                              (action_i == cln_pkg::ActChar);
          hdr_d.prefix_byte = char_code_i;
          mag_d             = number_i;
          if (action_i == cln_pkg::ActSigned) begin
            if (number_i[15]) begin
              hdr_d.prefix_byte = cln_pkg::AsciiMinus;
              mag_d             = 16'(-number_i);
            end else begin
              hdr_d.prefix_byte = cln_pkg::AsciiPlus;
            end
          end
          if (action_i <= cln_pkg::ActBinary) begin
            if (digit_count_i > 5'(MAX_DIGITS)) begin
              cnt_d = CntW'(MAX_DIGITS);
            end else begin
              cnt_d = CntW'(digit_count_i);
            end
          end else begin
            cnt_d = '0;
          end
          is_dec_d = (action_i == cln_pkg::ActUnsigned) ||
                     (action_i == cln_pkg::ActSigned);
          is_bin_d = (action_i == cln_pkg::ActBinary);
          bcd_d    = '0;
          bit_d    = '0;
          if (is_dec_d) begin
            state_d = cln_pkg::FR_CONV;
          end else begin
            state_d = cln_pkg::FR_PUSH;
          end
        end
      end
      cln_pkg::FR_CONV: begin
        bcd_d = {bcd_adj[BcdW-2:0], mag_q[15]};
        mag_d = {mag_q[14:0], 1'b0};
        bit_d = bit_q + 4'd1;
        if (bit_q == 4'hF) begin
          state_d = cln_pkg::FR_PUSH;
        end
      end
      cln_pkg::FR_PUSH: begin
        job_valid_o = 1'b1;
        if (job_ready_i) begin
          state_d = cln_pkg::FR_IDLE;
        end
      end
      default: begin
        state_d = cln_pkg::FR_IDLE;
      end
    endcase
  end

  // digit store, least significant digit in the low nibble
  always_comb begin
    if (is_dec_q) begin
      src_digits = {{(SrcW - BcdW){1'b0}}, bcd_q};
    end else if (is_bin_q) begin
      for (int j = 0; j < int'(cln_pkg::SrcDigits); j++) begin
        src_digits[4*j +: 4] = {3'b000, mag_q[j]};
      end
    end else begin
      src_digits = {{(SrcW - 16){1'b0}}, mag_q};
    end
  end

  assign job_hdr_o    = hdr_q;
  assign job_cnt_o    = cnt_q;
  assign job_digits_o = src_digits[4*MAX_DIGITS-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cln_pkg::FR_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hdr_q    <= hdr_d;
    cnt_q    <= cnt_d;
    mag_q    <= mag_d;
    bcd_q    <= bcd_d;
    bit_q    <= bit_d;
    is_dec_q <= is_dec_d;
    is_bin_q <= is_bin_d;
  end

endmodule

`default_nettype wire

[src/cln_queue.sv]
// ----------------------------------------------------------------------------
// cln_queue: two-entry job queue
// decouples request intake from the bus write sequencer
// ----------------------------------------------------------------------------
`default_nettype none

module cln_queue #(
  parameter int unsigned WIDTH = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [WIDTH-1:0] in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [WIDTH-1:0]      out_data_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wr_ptr_q;
  logic             rd_ptr_q;
  logic [1:0]       fill_q;
  logic             push;
  logic             pop;

  assign in_ready_o  = (fill_q != 2'd2);
  assign out_valid_o = (fill_q != 2'd0);
  assign out_data_o  = mem_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push && !pop) begin
        fill_q <= fill_q + 2'd1;
      end else if (pop && !push) begin
        fill_q <= fill_q - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

[src/cln_back.sv]
// ----------------------------------------------------------------------------
// cln_back: bus write sequencer
// emits the address command, the optional prefix byte and the digits of a
// job, one word per cycle while the receiver is ready, through an output register
// ----------------------------------------------------------------------------
`default_nettype none

module cln_back #(
  parameter int unsigned MAX_DIGITS = cln_pkg::DefaultMaxDigits,
  localparam int unsigned CntW = $clog2(MAX_DIGITS + 1),
  localparam int unsigned IdxW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    job_valid_i,
  output logic                         job_ready_o,
  input  wire cln_pkg::job_hdr_t       job_hdr_i,
  input  wire logic [CntW-1:0]         job_cnt_i,
  input  wire logic [4*MAX_DIGITS-1:0] job_digits_i,
  output logic                         out_valid_o,
  input  wire logic                    out_ready_i,
  output logic                         is_data_o,
  output logic [7:0]                   bus_byte_o,
  output logic                         last_o
);

  cln_pkg::bk_state_e state_q, state_d;
  cln_pkg::job_hdr_t  hdr_q, hdr_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic [3:0]         digits_q [MAX_DIGITS];
  logic               load_job;

  logic               out_valid_q, out_valid_d;
  logic               out_is_data_q, out_is_data_d;
  logic [7:0]         out_byte_q, out_byte_d;
  logic               out_last_q, out_last_d;

  logic               adv;
  logic [CntW-1:0]    cnt_m1;
  logic [IdxW-1:0]    idx;

  assign adv    = !out_valid_q || out_ready_i;
  assign cnt_m1 = cnt_q - CntW'(1);
  assign idx    = cnt_m1[IdxW-1:0];

  always_comb begin
    state_d       = state_q;
    hdr_d         = hdr_q;
    cnt_d         = cnt_q;
    load_job      = 1'b0;
    job_ready_o   = 1'b0;
    out_valid_d   = out_valid_q && !out_ready_i;
    out_is_data_d = out_is_data_q;
    out_byte_d    = out_byte_q;
    out_last_d    = out_last_q;
    case (state_q)
      cln_pkg::BK_IDLE: begin
        job_ready_o = adv;
        if (job_valid_i && adv) begin
          load_job      = 1'b1;
          hdr_d         = job_hdr_i;
          cnt_d         = job_cnt_i;
          out_valid_d   = 1'b1;
          out_is_data_d = 1'b0;
          out_byte_d    = job_hdr_i.addr_cmd;
          out_last_d    = !job_hdr_i.has_prefix && (job_cnt_i == '0);
          if (job_hdr_i.has_prefix) begin
            state_d = cln_pkg::BK_PREFIX;
          end else if (job_cnt_i != '0) begin
            state_d = cln_pkg::BK_DIGITS;
          end
        end
      end
      cln_pkg::BK_PREFIX: begin
        if (adv) begin
          out_valid_d   = 1'b1;
          out_is_data_d = 1'b1;
          out_byte_d    = hdr_q.prefix_byte;
          out_last_d    = (cnt_q == '0);
          if (cnt_q == '0) begin
            state_d = cln_pkg::BK_IDLE;
          end else begin
            state_d = cln_pkg::BK_DIGITS;
          end
        end
      end
      cln_pkg::BK_DIGITS: begin
        if (adv) begin
          out_valid_d   = 1'b1;
          out_is_data_d = 1'b1;
          out_byte_d    = cln_pkg::digit_to_ascii(digits_q[idx]);
          out_last_d    = (cnt_q == CntW'(1));
          cnt_d         = cnt_m1;
          if (cnt_q == CntW'(1)) begin
            state_d = cln_pkg::BK_IDLE;
          end
        end
      end
      default: begin
        state_d = cln_pkg::BK_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign is_data_o   = out_is_data_q;
  assign bus_byte_o  = out_byte_q;
  assign last_o      = out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cln_pkg::BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hdr_q         <= hdr_d;
    cnt_q         <= cnt_d;
    out_is_data_q <= out_is_data_d;
    out_byte_q    <= out_byte_d;
    out_last_q    <= out_last_d;
    if (load_job) begin
      for (int i = 0; i < int'(MAX_DIGITS); i++) begin
        digits_q[i] <= job_digits_i[4*i +: 4];
      end
    end
  end

  // digit phase never runs with nothing left to emit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cln_pkg::BK_DIGITS) |-> (cnt_q != '0))
    else $error("digit phase with zero digits left");

  // prefix phase only for jobs that carry a prefix
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cln_pkg::BK_PREFIX) |-> hdr_q.has_prefix)
    else $error("prefix phase without prefix");

  // while a job is still running, the pending word is not its last
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q != cln_pkg::BK_IDLE) && out_valid_q) |-> !out_last_q)
    else $error("last flagged before job end");

  // a new job is taken only when the previous one has flagged its last word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_job && out_valid_q) |-> out_last_q)
    else $error("job loaded before previous job ended");

endmodule

`default_nettype wire

[src/char_lcd_number_formatter.sv]
// ----------------------------------------------------------------------------
// char_lcd_number_formatter: lcd bus writes for one display request
// turns a request (character or number) into hd44780 style bus words
// ----------------------------------------------------------------------------
// usage:
//   input channel (in_valid_i / in_ready_o) takes one request word: action,
//   line, column, number, digit count and character code
//   output channel (out_valid_o / out_ready_i) gives one bus word per
//   handshake: is_data_o, bus_byte_o and last_o on the final word
//   each request gives a set-address command, then an optional prefix byte
//   (sign or character), then up to MAX_DIGITS digits, msd first
// timing:
//   decimal requests first pass through the front end bcd converter (one
//   bit per cycle), then every request is handed on from a push state into the
//   two-entry job queue between front end and sequencer
//   the front end takes no new request until its current job is in the queue
//   the sequencer emits one word per cycle while the receiver is ready, up to
//   18 words per request
// reset: drops all queued jobs and any pending output word
// stall: a stalled receiver holds the output register; the queue absorbs
//   up to two finished jobs and the front end holds one more before the
//   input stops accepting
// ----------------------------------------------------------------------------
`default_nettype none

module char_lcd_number_formatter #(
  parameter int unsigned MAX_DIGITS = cln_pkg::DefaultMaxDigits
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // request channel
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [2:0]  action_i,
  input  wire logic [1:0]  line_i,
  input  wire logic [5:0]  column_i,
  input  wire logic [15:0] number_i,
  input  wire logic [4:0]  digit_count_i,
  input  wire logic [7:0]  char_code_i,
  // bus word channel
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             is_data_o,
  output logic [7:0]       bus_byte_o,
  output logic             last_o
);

  localparam int unsigned CntW  = $clog2(MAX_DIGITS + 1);
  localparam int unsigned DigW  = 4 * MAX_DIGITS;
  localparam int unsigned HdrW  = $bits(cln_pkg::job_hdr_t);
  localparam int unsigned JobW  = HdrW + CntW + DigW;

  // front end to queue
  logic                fr_valid;
  logic                fr_ready;
  cln_pkg::job_hdr_t   fr_hdr;
  logic [CntW-1:0]     fr_cnt;
  logic [DigW-1:0]     fr_digits;

  // queue to sequencer
  logic                bk_valid;
  logic                bk_ready;
  logic [JobW-1:0]     bk_job;
  cln_pkg::job_hdr_t   bk_hdr;
  logic [CntW-1:0]     bk_cnt;
  logic [DigW-1:0]     bk_digits;

  cln_front #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .action_i      (action_i),
    .line_i        (line_i),
    .column_i      (column_i),
    .number_i      (number_i),
    .digit_count_i (digit_count_i),
    .char_code_i   (char_code_i),
    .job_valid_o   (fr_valid),
    .job_ready_i   (fr_ready),
    .job_hdr_o     (fr_hdr),
    .job_cnt_o     (fr_cnt),
    .job_digits_o  (fr_digits)
  );

  // job word: header, digit count, digit store
  cln_queue #(
    .WIDTH (JobW)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (fr_valid),
    .in_ready_o  (fr_ready),
    .in_data_i   ({fr_hdr, fr_cnt, fr_digits}),
    .out_valid_o (bk_valid),
    .out_ready_i (bk_ready),
    .out_data_o  (bk_job)
  );

  assign bk_hdr    = bk_job[JobW-1 -: HdrW];
  assign bk_cnt    = bk_job[DigW +: CntW];
  assign bk_digits = bk_job[DigW-1:0];

  cln_back #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_valid_i  (bk_valid),
    .job_ready_o  (bk_ready),
    .job_hdr_i    (bk_hdr),
    .job_cnt_i    (bk_cnt),
    .job_digits_i (bk_digits),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .is_data_o    (is_data_o),
    .bus_byte_o   (bus_byte_o),
    .last_o       (last_o)
  );

endmodule

`default_nettype wire

[tb/char_lcd_number_formatter_tb.sv]
// ----------------------------------------------------------------------------
// char_lcd_number_formatter_tb: self-checking bench for the lcd formatter
// drives display requests through the request channel and checks every bus
// word against a local model of the address command, sign, digit and
// character writes; both channels idle at random
// ----------------------------------------------------------------------------
module char_lcd_number_formatter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxDigits = cln_pkg::DefaultMaxDigits;
  // cycles without any handshake before the run is declared hung
  localparam int unsigned HangLimit = 5000;
  // settle time after the last word, a bit over one full request
  localparam int unsigned TailCycles = 40;
  localparam int unsigned RandomReqs = 138;

  // action codes the block ignores apart from the address command
  localparam logic [2:0] ActSpare5 = 3'd5;
  localparam logic [2:0] ActSpare6 = 3'd6;
  localparam logic [2:0] ActSpare7 = 3'd7;
  localparam logic [1:0] SecondLine = 2'd2;

  typedef struct {
    logic [2:0]  action;
    logic [1:0]  line;
    logic [5:0]  column;
    logic [15:0] number;
    logic [4:0]  digit_count;
    logic [7:0]  char_code;
    bit          hold_for_drain;  // sender waits for all words before this one
  } lcd_req_t;

  typedef struct packed {
    logic       is_data;
    logic [7:0] bus_byte;
    logic       last;
  } bus_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [2:0]  action_i = '0;
  logic [1:0]  line_i = '0;
  logic [5:0]  column_i = '0;
  logic [15:0] number_i = '0;
  logic [4:0]  digit_count_i = '0;
  logic [7:0]  char_code_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        is_data_o;
  logic [7:0]  bus_byte_o;
  logic        last_o;

  lcd_req_t    pending_reqs_q[$];
  bus_word_t   bus_words_due_q[$];
  int unsigned reqs_planned;
  int unsigned reqs_accepted = 0;
  int unsigned err_count = 0;
  int unsigned words_seen = 0;
  logic        in_fire = 1'b0;     // request taken at the last rising edge
  int unsigned burst_left = 1;
  int unsigned gap_left = 0;
  int unsigned stall_mode = 0;
  int unsigned stall_span = 0;
  int unsigned stall_phase = 0;
  int unsigned idle_cycles = 0;

  char_lcd_number_formatter DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .action_i     (action_i),
    .line_i       (line_i),
    .column_i     (column_i),
    .number_i     (number_i),
    .digit_count_i(digit_count_i),
    .char_code_i  (char_code_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .is_data_o    (is_data_o),
    .bus_byte_o   (bus_byte_o),
    .last_o       (last_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // ascii character of digit pos (0 = least significant) of value in radix;
  // repeated division gives '0' past the top of the value on its own
  function automatic logic [7:0] digit_char(input logic [16:0] value,
                                            input int unsigned radix,
                                            input int unsigned pos);
    logic [16:0] v;
    int unsigned d;
    v = value;
    for (int unsigned p = 0; p < pos; p++) v = 17'(v / radix);
    d = v % radix;
    if (d < 10) return cln_pkg::AsciiZero + 8'(d);
    return cln_pkg::AsciiUpperA + 8'(d - 10);
  endfunction

  // works out every bus word one request causes and queues them in order
  function automatic void format_request(input lcd_req_t r);
    bus_word_t   words[$];
    logic [7:0]  addr;
    logic [16:0] mag;
    int unsigned radix;
    int unsigned n_digits;
    // one-based column; column zero wraps to the top of the address space
    addr = {2'b00, r.column} - 8'd1;
    if (r.line != cln_pkg::FirstLine) addr = addr + cln_pkg::Line2Offset;
    words.push_back('{1'b0, cln_pkg::CmdSetAddr | addr, 1'b0});
    n_digits = (r.digit_count > MaxDigits) ? MaxDigits : r.digit_count;
    mag = {1'b0, r.number};
    radix = 10;
    case (r.action)
      cln_pkg::ActChar: words.push_back('{1'b1, r.char_code, 1'b0});
      cln_pkg::ActSigned: begin
        // sign always written, digits show the 16-bit magnitude
        if (r.number[15]) begin
          words.push_back('{1'b1, cln_pkg::AsciiMinus, 1'b0});
          mag = 17'h10000 - {1'b0, r.number};
        end else begin
          words.push_back('{1'b1, cln_pkg::AsciiPlus, 1'b0});
        end
      end
      cln_pkg::ActHex:    radix = 16;
      cln_pkg::ActBinary: radix = 2;
      default: ;
    endcase
    if (r.action <= cln_pkg::ActBinary) begin
      for (int unsigned i = n_digits; i > 0; i--) begin
        words.push_back('{1'b1, digit_char(mag, radix, i - 1), 1'b0});
      end
    end
    words[words.size() - 1].last = 1'b1;
    foreach (words[j]) bus_words_due_q.push_back(words[j]);
  endfunction

  task automatic flag_mismatch(input string what);
    $display("%0t ns: mismatch on bus word %0d: %s", $time, words_seen, what);
    err_count++;
  endtask

  function automatic void add_req(input logic [2:0] action, input logic [1:0] line,
                                  input logic [5:0] column, input logic [15:0] number,
                                  input logic [4:0] count, input logic [7:0] ch,
                                  input bit hold);
    lcd_req_t r;
    r = '{action, line, column, number, count, ch, hold};
    pending_reqs_q.push_back(r);
  endfunction

  // request sender: bursts of random length with random gaps; a word once
  // offered holds until taken
  always @(negedge clk_i) begin : req_sender
    lcd_req_t nxt;
    logic     drive;
    drive = 1'b0;
    if (rst_ni && !(in_valid_i && !in_fire)) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_reqs_q.size() > 0 &&
                   !(pending_reqs_q[0].hold_for_drain && bus_words_due_q.size() > 0)) begin
        nxt = pending_reqs_q.pop_front();
        drive = 1'b1;
        action_i      <= nxt.action;
        line_i        <= nxt.line;
        column_i      <= nxt.column;
        number_i      <= nxt.number;
        digit_count_i <= nxt.digit_count;
        char_code_i   <= nxt.char_code;
        burst_left--;
        if (burst_left == 0) begin
          // mostly short bursts, now and then a long back-to-back stretch
          burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 30)
                                                   : $urandom_range(1, 6);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
        end
      end
      in_valid_i <= drive;
    end
  end

  // receiver: stall behavior switches between modes every so often
  always @(negedge clk_i) begin : word_receiver
    logic rdy;
    if (stall_span == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_span = $urandom_range(20, 200);
    end
    stall_span--;
    stall_phase++;
    case (stall_mode)
      0:       rdy = 1'b1;                              // never stalls
      1:       rdy = ($urandom_range(0, 3) != 0);       // light stalls
      2:       rdy = ($urandom_range(0, 3) == 0);       // heavy stalls
      default: rdy = ((stall_phase % 3) == 0);          // ready when stall_phase is a multiple of three
    endcase
    out_ready_i <= rdy;
  end

  // sampling at the rising edge: requests into the model, words checked
  always @(posedge clk_i) begin : bus_monitor
    lcd_req_t  seen;
    bus_word_t got;
    bus_word_t want;
    in_fire <= rst_ni && in_valid_i && in_ready_o;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        seen = '{action_i, line_i, column_i, number_i, digit_count_i, char_code_i, 1'b0};
        format_request(seen);
        reqs_accepted++;
      end
      if (out_valid_o && out_ready_i) begin
        got = '{is_data_o, bus_byte_o, last_o};
        if (bus_words_due_q.size() == 0) begin
          flag_mismatch($sformatf("unexpected word rs=%b byte=%02h last=%b",
                                  got.is_data, got.bus_byte, got.last));
        end else begin
          want = bus_words_due_q.pop_front();
          if (got.is_data !== want.is_data)
            flag_mismatch($sformatf("is_data %b, want %b", got.is_data, want.is_data));
          if (got.bus_byte !== want.bus_byte)
            flag_mismatch($sformatf("bus_byte %02h, want %02h", got.bus_byte, want.bus_byte));
          if (got.last !== want.last)
            flag_mismatch($sformatf("last %b, want %b", got.last, want.last));
        end
        words_seen++;
      end
    end
  end

  // hang detector: any handshake on either channel restarts the count
  always @(posedge clk_i) begin : watchdog
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= HangLimit) begin
          $display("timeout with %0d words still expected", bus_words_due_q.size());
          $display("char_lcd_number_formatter test failed");
          $finish;
        end
      end
    end
  end

  initial begin
    lcd_req_t r;
    int unsigned pick;

    // directed part: field extremes, every mode, wrap and saturation cases
    add_req(cln_pkg::ActUnsigned, cln_pkg::FirstLine, 6'd1,  16'd0,     5'd5,  8'h00, 1'b0);
    add_req(cln_pkg::ActUnsigned, SecondLine,         6'd40, 16'hFFFF,  5'd16, 8'h00, 1'b0);
    add_req(cln_pkg::ActUnsigned, cln_pkg::FirstLine, 6'd7,  16'd12345, 5'd0,  8'h00, 1'b0);
    add_req(cln_pkg::ActSigned,   cln_pkg::FirstLine, 6'd2,  16'h8000,  5'd6,  8'h00, 1'b0);
    add_req(cln_pkg::ActSigned,   SecondLine,         6'd3,  16'h7FFF,  5'd5,  8'h00, 1'b0);
    add_req(cln_pkg::ActSigned,   cln_pkg::FirstLine, 6'd4,  16'hFFFF,  5'd1,  8'h00, 1'b0);
    add_req(cln_pkg::ActSigned,   SecondLine,         6'd5,  16'h8001,  5'd0,  8'h00, 1'b0);
    add_req(cln_pkg::ActSigned,   cln_pkg::FirstLine, 6'd6,  16'h0000,  5'd16, 8'h00, 1'b0);
    add_req(cln_pkg::ActHex,      cln_pkg::FirstLine, 6'd8,  16'hABCD,  5'd4,  8'h00, 1'b0);
    add_req(cln_pkg::ActHex,      SecondLine,         6'd9,  16'h1234,  5'd16, 8'h00, 1'b0);
    add_req(cln_pkg::ActBinary,   cln_pkg::FirstLine, 6'd10, 16'hA5A5,  5'd16, 8'h00, 1'b0);
    // the next request waits for the pipeline to empty first
    add_req(cln_pkg::ActBinary,   SecondLine,         6'd11, 16'h5A5A,  5'd31, 8'h00, 1'b1);
    add_req(cln_pkg::ActUnsigned, cln_pkg::FirstLine, 6'd12, 16'd65535, 5'd17, 8'h00, 1'b0);
    add_req(cln_pkg::ActChar,     cln_pkg::FirstLine, 6'd13, 16'h0000,  5'd0,  8'h00, 1'b0);
    add_req(cln_pkg::ActChar,     2'd0,               6'd14, 16'hFFFF,  5'd31, 8'hFF, 1'b0);
    add_req(cln_pkg::ActChar,     2'd3,               6'd63, 16'h0000,  5'd3,  8'h41, 1'b0);
    // column zero wraps on both lines
    add_req(cln_pkg::ActHex,      cln_pkg::FirstLine, 6'd0,  16'hF00F,  5'd4,  8'h00, 1'b0);
    add_req(cln_pkg::ActHex,      SecondLine,         6'd0,  16'h0FF0,  5'd4,  8'h00, 1'b0);
    add_req(cln_pkg::ActBinary,   cln_pkg::FirstLine, 6'd20, 16'h0001,  5'd0,  8'h00, 1'b0);
    add_req(ActSpare5,            cln_pkg::FirstLine, 6'd21, 16'h1111,  5'd8,  8'h55, 1'b0);
    add_req(ActSpare6,            SecondLine,         6'd22, 16'h2222,  5'd16, 8'hAA, 1'b0);
    add_req(ActSpare7,            2'd3,               6'd23, 16'h3333,  5'd31, 8'h33, 1'b0);

    // random part, weighted toward the modes that produce digits
    for (int unsigned n = 0; n < RandomReqs; n++) begin
      pick = $urandom_range(0, 19);
      r.action = (pick < 18) ? 3'(pick % 5) : 3'($urandom_range(5, 7));
      r.line = ($urandom_range(0, 1) == 0) ? cln_pkg::FirstLine : 2'($urandom_range(0, 3));
      r.column = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(0, 63))
                                             : 6'($urandom_range(1, 40));
      case ($urandom_range(0, 4))
        0:       r.number = 16'($urandom_range(0, 99));
        1:       r.number = 16'h8000 ^ 16'($urandom_range(0, 3));
        2:       r.number = 16'hFFFF - 16'($urandom_range(0, 15));
        default: r.number = 16'($urandom_range(0, 65535));
      endcase
      r.digit_count = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(17, 31))
                                                  : 5'($urandom_range(0, 16));
      r.char_code = 8'($urandom_range(0, 255));
      r.hold_for_drain = (n == RandomReqs / 2);
      pending_reqs_q.push_back(r);
    end
    reqs_planned = pending_reqs_q.size();

    // reset held for a while, then released away from either clock edge
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    #5 rst_ni = 1'b1;

    while (reqs_accepted < reqs_planned || bus_words_due_q.size() > 0) @(posedge clk_i);
    // let any stray word show up before the verdict
    repeat (TailCycles) @(posedge clk_i);

    if (err_count == 0) begin
      $display("char_lcd_number_formatter test passed");
    end else begin
      $display("char_lcd_number_formatter test failed");
    end
    $finish;
  end

endmodule
